// File: src/mfr_pkg.sv
// ----------------------------------------------------------------------------
// mfr_pkg: shared types and constants of the RGB median filter
// Pixel and transaction payload types, register indexes and fixed widths.
// ----------------------------------------------------------------------------
package mfr_pkg;

   localparam int DEF_WINDOW    = 3;
   localparam int DEF_MAX_WIDTH = 1024;
   localparam int MAX_HEIGHT    = 4096;

   localparam int CHAN_W     = 8;
   localparam int CFG_W_W    = 11;
   localparam int CFG_H_W    = 13;
   localparam int FH_W       = 13;
   localparam int ROW_W      = 12;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [CFG_W_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
   localparam logic [CFG_H_W-1:0] RST_IMAGE_HEIGHT = 13'd480;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic              action;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } req_payload_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
      logic              frame_last;
   } rsp_payload_type;

   typedef struct packed {
      logic pix;
      logic emit;
      logic inner;
      logic last;
   } s1_ctrl_type;

endpackage

// File: src/mfr_stream_if.sv
// ----------------------------------------------------------------------------
// mfr_stream_if: valid/ready stream channel
// Carries one payload per transaction; source drives valid and payload.
// ----------------------------------------------------------------------------
interface mfr_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: src/median_filter_rgb_top.sv
// ----------------------------------------------------------------------------
// median_filter_rgb_top: streaming RGB median filter
// Raster-order pixel stream in, per-channel WINDOW x WINDOW median out.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one transaction per pixel (action 0) or drain tick
//   (action 1). rsp_chan carries filtered pixels; frame_last marks the final
//   pixel of a frame. csr_* writes image_width (index 0) and image_height
//   (index 1); both are sampled at the first pixel of each frame.
//   The result for raster position k leaves with input k + HALF*width + HALF;
//   after the last pixel, one drain tick per pending result flushes the rest.
//   Edge pixels pass through unchanged.
//   Throughput: one transaction per cycle unless rsp_chan stalls, set by the
//   line store write plus two reads per bank. A transaction's result reaches
//   rsp_chan.valid through the registered memory read, then the result
//   register. A stalled receiver holds the result register; at most one
//   more transaction is taken into the read stage before req_chan.ready drops.
//   Reset (synchronous) returns the registers to 640 x 480 and empties the
//   pipeline; no clearing pass is needed.
// ----------------------------------------------------------------------------
module median_filter_rgb_top
   import mfr_pkg::*;
#(
   parameter int WINDOW    = DEF_WINDOW,
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   mfr_stream_if.sink            req_chan,
   mfr_stream_if.source          rsp_chan
);

   localparam int HALF   = WINDOW / 2;
   localparam int SIDE   = 2 * HALF + 1;
   localparam int NWIN   = SIDE * SIDE;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int FW_W   = $clog2(MAX_WIDTH + 1);
   localparam int TOT_W  = FW_W + FH_W;
   localparam int SLOT_W = $clog2(SIDE);

   // configuration
   logic [CFG_W_W-1:0] img_w_ff;
   logic [CFG_H_W-1:0] img_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= RST_IMAGE_WIDTH;
         img_h_ff <= RST_IMAGE_HEIGHT;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  img_w_ff <= csr_data[CFG_W_W-1:0];
            CSR_IMAGE_HEIGHT: img_h_ff <= csr_data[CFG_H_W-1:0];
            default: ;
         endcase
      end
   end

   // frame and position counters
   logic [FW_W-1:0]   fw_ff, fw_in;
   logic [FH_W-1:0]   fh_ff, fh_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [TOT_W-1:0]  in_cnt_ff, in_cnt_in;
   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [SLOT_W-1:0] in_slot_ff, in_slot_in;
   logic [TOT_W-1:0]  out_pos_ff, out_pos_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;
   logic [SLOT_W-1:0] out_slot_ff, out_slot_in;

   logic              accept, in_ready, out_adv;
   logic              is_pix, start, emit, last, inner;
   logic [FW_W-1:0]   clamp_w, cur_w;
   logic [FH_W-1:0]   clamp_h, cur_h;
   logic [TOT_W-1:0]  cur_total, lag;
   logic [TOT_W:0]    need;
   req_payload_type   req_p;
   pixel_type         req_pix;

   s1_ctrl_type       s1_ff;
   logic [SLOT_W-1:0] s1_slot_ff, s1_oslot_ff;
   pixel_type         s1_pix_ff;

   logic              out_vld_ff;
   rsp_payload_type   out_ff;

   assign req_p   = req_chan.payload;
   assign req_pix = '{red: req_p.red, green: req_p.green, blue: req_p.blue};

   assign out_adv  = !out_vld_ff || rsp_chan.ready;
   assign in_ready = !(s1_ff.pix || s1_ff.emit) || out_adv;
   assign accept   = req_chan.valid && in_ready;
   assign req_chan.ready = in_ready;

   always_comb begin
      if (img_w_ff == '0) begin
         clamp_w = FW_W'(1);
      end else if (32'(img_w_ff) > MAX_WIDTH) begin
         clamp_w = FW_W'(MAX_WIDTH);
      end else begin
         clamp_w = FW_W'(img_w_ff);
      end
      if (img_h_ff == '0) begin
         clamp_h = FH_W'(1);
      end else if (32'(img_h_ff) > MAX_HEIGHT) begin
         clamp_h = FH_W'(MAX_HEIGHT);
      end else begin
         clamp_h = img_h_ff;
      end

      is_pix    = !req_p.action && ((in_cnt_ff == '0) || (in_cnt_ff < total_ff));
      start     = is_pix && (in_cnt_ff == '0);
      cur_w     = start ? clamp_w : fw_ff;
      cur_h     = start ? clamp_h : fh_ff;
      cur_total = start ? (TOT_W'(clamp_w) * TOT_W'(clamp_h)) : total_ff;
      lag       = TOT_W'(HALF) * TOT_W'(cur_w) + TOT_W'(HALF);
      need      = {1'b0, out_pos_ff} + {1'b0, lag};

      if (is_pix) begin
         emit = (out_pos_ff < cur_total) && ({1'b0, in_cnt_ff} >= need);
      end else begin
         emit = (total_ff != '0) && (in_cnt_ff == total_ff) && (out_pos_ff < total_ff);
      end
      last  = ((out_pos_ff + TOT_W'(1)) == cur_total);
      inner = (32'(out_row_ff) >= HALF) && (32'(out_row_ff) + HALF < 32'(cur_h)) &&
              (32'(out_col_ff) >= HALF) && (32'(out_col_ff) + HALF < 32'(cur_w));

      fw_in       = fw_ff;
      fh_in       = fh_ff;
      total_in    = total_ff;
      in_cnt_in   = in_cnt_ff;
      in_col_in   = in_col_ff;
      in_slot_in  = in_slot_ff;
      out_pos_in  = out_pos_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_slot_in = out_slot_ff;

      if (accept && is_pix) begin
         fw_in     = cur_w;
         fh_in     = cur_h;
         total_in  = cur_total;
         in_cnt_in = in_cnt_ff + TOT_W'(1);
         if ((FW_W'(in_col_ff) + FW_W'(1)) >= cur_w) begin
            in_col_in  = '0;
            in_slot_in = (in_slot_ff == SLOT_W'(SIDE - 1)) ? '0 : in_slot_ff + SLOT_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
      end

      if (accept && emit) begin
         out_pos_in = out_pos_ff + TOT_W'(1);
         if ((FW_W'(out_col_ff) + FW_W'(1)) >= cur_w) begin
            out_col_in  = '0;
            out_row_in  = out_row_ff + ROW_W'(1);
            out_slot_in = (out_slot_ff == SLOT_W'(SIDE - 1)) ? '0 : out_slot_ff + SLOT_W'(1);
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
         // frame done: drop back to idle
         if (last) begin
            total_in    = '0;
            in_cnt_in   = '0;
            in_col_in   = '0;
            in_slot_in  = '0;
            out_pos_in  = '0;
            out_col_in  = '0;
            out_row_in  = '0;
            out_slot_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff       <= '0;
         fh_ff       <= '0;
         total_ff    <= '0;
         in_cnt_ff   <= '0;
         in_col_ff   <= '0;
         in_slot_ff  <= '0;
         out_pos_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_slot_ff <= '0;
      end else begin
         fw_ff       <= fw_in;
         fh_ff       <= fh_in;
         total_ff    <= total_in;
         in_cnt_ff   <= in_cnt_in;
         in_col_ff   <= in_col_in;
         in_slot_ff  <= in_slot_in;
         out_pos_ff  <= out_pos_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_slot_ff <= out_slot_in;
      end
   end

   // line store
   pixel_type rd_a [SIDE];
   pixel_type rd_b [SIDE];

   mfr_line_store #(
      .BANKS (SIDE),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock     (clock),
      .wr_en     (accept && is_pix),
      .wr_slot   (in_slot_ff),
      .wr_addr   (in_col_ff),
      .wr_data   (req_pix),
      .rd_en     (in_ready),
      .rd_addr_a (in_col_ff),
      .rd_addr_b (out_col_ff),
      .rd_a      (rd_a),
      .rd_b      (rd_b)
   );

   // read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else if (in_ready) begin
         s1_ff <= '{pix: accept && is_pix, emit: accept && emit, inner: inner, last: last};
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         s1_slot_ff  <= in_slot_ff;
         s1_oslot_ff <= out_slot_ff;
         s1_pix_ff   <= req_pix;
      end
   end

   // newest column: the bank being written holds the oldest row, so take the
   // incoming pixel in its place
   pixel_type col [SIDE];
   pixel_type hist_ff [SIDE-1][SIDE];

   always_comb begin
      for (int b = 0; b < SIDE; b++) begin
         col[b] = (s1_slot_ff == SLOT_W'(b)) ? s1_pix_ff : rd_a[b];
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && s1_ff.pix) begin
         for (int n = 0; n < SIDE - 2; n++) begin
            hist_ff[n] <= hist_ff[n+1];
         end
         hist_ff[SIDE-2] <= col;
      end
   end

   logic [CHAN_W-1:0] win_r [NWIN];
   logic [CHAN_W-1:0] win_g [NWIN];
   logic [CHAN_W-1:0] win_b [NWIN];
   logic [CHAN_W-1:0] med_r, med_g, med_b;

   always_comb begin
      for (int n = 0; n < SIDE; n++) begin
         for (int b = 0; b < SIDE; b++) begin
            if (n < SIDE - 1) begin
               win_r[n*SIDE+b] = hist_ff[n][b].red;
               win_g[n*SIDE+b] = hist_ff[n][b].green;
               win_b[n*SIDE+b] = hist_ff[n][b].blue;
            end else begin
               win_r[n*SIDE+b] = col[b].red;
               win_g[n*SIDE+b] = col[b].green;
               win_b[n*SIDE+b] = col[b].blue;
            end
         end
      end
   end

   mfr_median #(.N(NWIN)) u_med_r (.vals(win_r), .med(med_r));
   mfr_median #(.N(NWIN)) u_med_g (.vals(win_g), .med(med_g));
   mfr_median #(.N(NWIN)) u_med_b (.vals(win_b), .med(med_b));

   // result register
   pixel_type pass_pix;
   assign pass_pix = rd_b[s1_oslot_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_adv) begin
         out_vld_ff <= s1_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && s1_ff.emit) begin
         out_ff.out_red    <= s1_ff.inner ? med_r : pass_pix.red;
         out_ff.out_green  <= s1_ff.inner ? med_g : pass_pix.green;
         out_ff.out_blue   <= s1_ff.inner ? med_b : pass_pix.blue;
         out_ff.frame_last <= s1_ff.last;
      end
   end

   assign rsp_chan.valid   = out_vld_ff;
   assign rsp_chan.payload = out_ff;

endmodule

// File: src/mfr_line_store.sv
// ----------------------------------------------------------------------------
// mfr_line_store: banked row memory
// One bank per window row, one write port, two registered read ports per bank.
// ----------------------------------------------------------------------------
module mfr_line_store
   import mfr_pkg::*;
#(
   parameter int BANKS = 3,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH),
   localparam int SLOT_W = $clog2(BANKS)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [SLOT_W-1:0] wr_slot,
   input  logic [ADDR_W-1:0] wr_addr,
   input  pixel_type         wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output pixel_type         rd_a [BANKS],
   output pixel_type         rd_b [BANKS]
);

   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      pixel_type mem_ff [DEPTH];
      pixel_type rd_a_ff;
      pixel_type rd_b_ff;

      always_ff @(posedge clock) begin
         if (wr_en && (wr_slot == SLOT_W'(b))) begin
            mem_ff[wr_addr] <= wr_data;
         end
         if (rd_en) begin
            rd_a_ff <= mem_ff[rd_addr_a];
            rd_b_ff <= mem_ff[rd_addr_b];
         end
      end

      assign rd_a[b] = rd_a_ff;
      assign rd_b[b] = rd_b_ff;
   end

endmodule

// File: src/mfr_median.sv
// ----------------------------------------------------------------------------
// mfr_median: median of an odd number of 8-bit values
// Ranks every value against all others in parallel and picks the middle rank.
// ----------------------------------------------------------------------------
module mfr_median
   import mfr_pkg::*;
#(
   parameter int N = 9
) (
   input  logic [CHAN_W-1:0] vals [N],
   output logic [CHAN_W-1:0] med
);

   always_comb begin
      logic [N-1:0] below;
      med   = '0;
      below = '0;
      for (int i = 0; i < N; i++) begin
         // break ties by position so exactly one value holds each rank
         for (int j = 0; j < N; j++) begin
            below[j] = (vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i));
         end
         if ($countones(below) == N / 2) begin
            med = vals[i];
         end
      end
   end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for median_filter_rgb_top
// Drives raster frames of many sizes through the filter, predicts each output
// pixel (3x3 per-channel median inside, pass-through at the edges) and checks
// every rsp_chan transaction in order against the prediction.
// ----------------------------------------------------------------------------
module tb;
   import mfr_pkg::*;

   localparam int HALF_WIN = DEF_WINDOW / 2;
   localparam int SIDE     = 2 * HALF_WIN + 1;
   localparam int DIR_ROWS = 26;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   mfr_stream_if #(.payload_type(req_payload_type)) req_if ();
   mfr_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   median_filter_rgb_top u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   // predictor state
   logic [CFG_W_W-1:0] cfg_width;
   logic [CFG_H_W-1:0] cfg_height;
   pixel_type          line_mem [SIDE][DEF_MAX_WIDTH];
   int unsigned        in_col, in_slot, in_count;
   int unsigned        out_pos, out_col, out_row;
   int unsigned        frame_w, frame_h, frame_total;

   rsp_payload_type    pixel_q [$];
   int                 error_count;
   int                 result_count;
   int                 item_count;
   int                 frame_count;
   bit                 stall_req;
   bit                 burst_mode;

   typedef struct {
      req_payload_type item;
      bit              typed;
      rsp_payload_type want;
   } dir_row_type;

   dir_row_type dir_rows [DIR_ROWS];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report(input string what, input int got, input int want);
      error_count++;
      if (error_count <= 30)
         $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   function automatic logic [7:0] median9(input logic [7:0] v [9]);
      logic [7:0] s [9];
      logic [7:0] t;
      s = v;
      for (int i = 0; i < 9; i++)
         for (int j = 0; j < 8 - i; j++)
            if (s[j] > s[j+1]) begin
               t = s[j]; s[j] = s[j+1]; s[j+1] = t;
            end
      return s[4];
   endfunction

   function automatic rsp_payload_type filter_pixel();
      rsp_payload_type r;
      logic [7:0]      vr [9];
      logic [7:0]      vg [9];
      logic [7:0]      vb [9];
      pixel_type       p;
      int unsigned     sl;
      bit              inner;
      inner = out_row >= HALF_WIN && out_row + HALF_WIN < frame_h &&
              out_col >= HALF_WIN && out_col + HALF_WIN < frame_w;
      if (inner) begin
         for (int m = 0; m < SIDE; m++) begin
            sl = (out_row - HALF_WIN + m) % SIDE;
            for (int n = 0; n < SIDE; n++) begin
               p = line_mem[sl][out_col - HALF_WIN + n];
               vr[m*SIDE+n] = p.red;
               vg[m*SIDE+n] = p.green;
               vb[m*SIDE+n] = p.blue;
            end
         end
         r.out_red   = median9(vr);
         r.out_green = median9(vg);
         r.out_blue  = median9(vb);
      end else begin
         p = line_mem[out_row % SIDE][out_col];
         r.out_red   = p.red;
         r.out_green = p.green;
         r.out_blue  = p.blue;
      end
      out_pos++;
      r.frame_last = (out_pos == frame_total);
      out_col++;
      if (out_col >= frame_w) begin
         out_col = 0;
         out_row++;
      end
      if (out_pos == frame_total) begin
         in_count = 0; in_col = 0; in_slot = 0;
         out_pos = 0; out_col = 0; out_row = 0; frame_total = 0;
      end
      return r;
   endfunction

   // advance the predictor by one accepted transaction
   function automatic bit predict_pixel(input req_payload_type it, output rsp_payload_type r);
      int unsigned w, h;
      if (!it.action && (in_count == 0 || in_count < frame_total)) begin
         if (in_count == 0) begin
            w = cfg_width;
            h = cfg_height;
            if (w == 0) w = 1;
            if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
            if (h == 0) h = 1;
            if (h > MAX_HEIGHT) h = MAX_HEIGHT;
            frame_w = w; frame_h = h; frame_total = w * h;
         end
         line_mem[in_slot][in_col] = '{it.red, it.green, it.blue};
         in_count++;
         in_col++;
         if (in_col >= frame_w) begin
            in_col = 0;
            in_slot = (in_slot + 1) % SIDE;
         end
         if (out_pos < frame_total && in_count >= out_pos + HALF_WIN * frame_w + HALF_WIN + 1) begin
            r = filter_pixel();
            return 1'b1;
         end
         return 1'b0;
      end
      if (frame_total > 0 && in_count == frame_total && out_pos < frame_total) begin
         r = filter_pixel();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic int pick_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) cfg_width = val[CFG_W_W-1:0];
      else cfg_height = val[CFG_H_W-1:0];
   endtask

   // send one transaction; typed expectation overrides the prediction
   task automatic send_item(input req_payload_type it, input bit typed = 0,
                            input rsp_payload_type want = '0);
      int              gap;
      rsp_payload_type r;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= it;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      item_count++;
      if (predict_pixel(it, r)) pixel_q.push_back(typed ? want : r);
      else if (typed) report("typed row without result", 0, 1);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic req_payload_type rand_pixel(input bit narrow);
      req_payload_type it;
      it.action = 1'b0;
      it.red    = narrow ? $urandom_range(100, 103) : $urandom_range(0, 255);
      it.green  = narrow ? $urandom_range(100, 103) : $urandom_range(0, 255);
      it.blue   = narrow ? $urandom_range(100, 103) : $urandom_range(0, 255);
      return it;
   endfunction

   // one frame: pixels with odd stray drains, then drains to flush the tail
   task automatic run_frame(input int unsigned w_reg, input int unsigned h_reg);
      int unsigned w, h, lag;
      bit          narrow;
      req_payload_type it;
      csr_write(CSR_IMAGE_WIDTH, w_reg);
      csr_write(CSR_IMAGE_HEIGHT, h_reg);
      w = (w_reg == 0) ? 1 : (w_reg > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : w_reg);
      h = (h_reg == 0) ? 1 : (h_reg > MAX_HEIGHT ? MAX_HEIGHT : h_reg);
      narrow = ($urandom_range(0, 3) == 0);
      burst_mode = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < w * h; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            it = rand_pixel(0);
            it.action = 1'b1;
            send_item(it);
         end
         send_item(rand_pixel(narrow));
      end
      lag = (w * h > HALF_WIN * w + HALF_WIN) ? HALF_WIN * w + HALF_WIN : w * h;
      for (int i = 0; i < lag; i++) begin
         // a pixel after the frame's input is complete acts as a drain
         it = rand_pixel(0);
         it.action = ($urandom_range(0, 3) != 0);
         send_item(it);
      end
      if ($urandom_range(0, 2) == 0) begin
         it = rand_pixel(0);
         it.action = 1'b1;
         send_item(it);
      end
      frame_count++;
      wait_drained();
   endtask

   // result side: random back-pressure plus one long hold on request
   initial begin
      int hold;
      hold = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (pixel_q.size() == 0) begin
               report("unexpected result", 1, 0);
            end else begin
               rsp_payload_type e, g;
               e = pixel_q.pop_front();
               g = rsp_if.payload;
               result_count++;
               if (g.out_red !== e.out_red) report("out_red", g.out_red, e.out_red);
               if (g.out_green !== e.out_green) report("out_green", g.out_green, e.out_green);
               if (g.out_blue !== e.out_blue) report("out_blue", g.out_blue, e.out_blue);
               if (g.frame_last !== e.frame_last)
                  report("frame_last", g.frame_last, e.frame_last);
            end
         end
         if (stall_req && hold == 0) begin
            stall_req = 1'b0;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_if.ready <= 1'b0;
         end else if (burst_mode) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) < 70) ||
                            ($urandom_range(0, 99) < 3 ? 1'b0 : 1'b0);
         end
      end
   end

   initial begin
      req_payload_type it;
      int              wv, hv;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_IMAGE_WIDTH;
      csr_data       = '0;
      reset          = 1'b1;
      error_count = 0; result_count = 0; item_count = 0; frame_count = 0;
      stall_req = 0; burst_mode = 0;
      cfg_width = RST_IMAGE_WIDTH; cfg_height = RST_IMAGE_HEIGHT;
      in_col = 0; in_slot = 0; in_count = 0;
      out_pos = 0; out_col = 0; out_row = 0;
      frame_w = 0; frame_h = 0; frame_total = 0;

      // single-pixel frames: the drain after each pixel returns it and ends the frame
      dir_rows[0] = '{'{1'b0, 8'd0,   8'd0,   8'd0},   0, '0};
      dir_rows[1] = '{'{1'b1, 8'd0,   8'd0,   8'd0},   1, '{8'd0,   8'd0,   8'd0,   1'b1}};
      dir_rows[2] = '{'{1'b0, 8'd255, 8'd255, 8'd255}, 0, '0};
      dir_rows[3] = '{'{1'b1, 8'd0,   8'd0,   8'd0},   1, '{8'd255, 8'd255, 8'd255, 1'b1}};
      dir_rows[4] = '{'{1'b0, 8'd255, 8'd0,   8'd0},   0, '0};
      dir_rows[5] = '{'{1'b1, 8'd0,   8'd0,   8'd0},   1, '{8'd255, 8'd0,   8'd0,   1'b1}};
      dir_rows[6] = '{'{1'b0, 8'd0,   8'd255, 8'd0},   0, '0};
      dir_rows[7] = '{'{1'b1, 8'd0,   8'd0,   8'd0},   1, '{8'd0,   8'd255, 8'd0,   1'b1}};
      dir_rows[8] = '{'{1'b0, 8'd0,   8'd0,   8'd255}, 0, '0};
      dir_rows[9] = '{'{1'b1, 8'd0,   8'd0,   8'd0},   1, '{8'd0,   8'd0,   8'd255, 1'b1}};
      // drain with nothing pending: no result
      dir_rows[10] = '{'{1'b1, 8'd0,   8'd0,   8'd0},   0, '0};
      dir_rows[11] = '{'{1'b1, 8'd170, 8'd85,  8'd170}, 0, '0};
      // 3x3 frame: one median in the centre, pixel acting as drain, stray drain
      for (int i = 0; i < 9; i++)
         dir_rows[12+i] = '{'{1'b0, 8'(i * 31), 8'(255 - i * 17), 8'((i * 97) % 256)}, 0, '0};
      dir_rows[21] = '{'{1'b0, 8'd1, 8'd2, 8'd3}, 0, '0};
      for (int i = 22; i < DIR_ROWS; i++) dir_rows[i] = '{'{1'b1, 8'd0, 8'd0, 8'd0}, 0, '0};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_write(CSR_IMAGE_WIDTH, 0);
      csr_write(CSR_IMAGE_HEIGHT, 0);
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (i == 12) begin
            wait_drained();
            csr_write(CSR_IMAGE_WIDTH, 3);
            csr_write(CSR_IMAGE_HEIGHT, 3);
         end
         send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end
      wait_drained();

      // zero registers acting as one, then a wider frame under a long hold
      run_frame(0, 6);
      run_frame(5, 0);
      stall_req = 1'b1;
      run_frame(60, 4);

      while (item_count < 950) begin
         case ($urandom_range(0, 9))
            0:       begin wv = $urandom_range(0, 2); hv = $urandom_range(0, 12); end
            1:       begin wv = $urandom_range(0, 12); hv = $urandom_range(0, 2); end
            default: begin wv = $urandom_range(3, 14); hv = $urandom_range(3, 10); end
         endcase
         run_frame(wv, hv);
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("covered %0d frames, %0d transactions in, %0d pixels checked",
               frame_count, item_count, result_count);
      $display("sizes from 1x1 up to 60 wide, zero-sized registers, long receiver hold");
      if (error_count == 0 && pixel_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
